// ===== src/timestamp_id_generator_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef TIMESTAMP_ID_GENERATOR_DEFINES_SVH
`define TIMESTAMP_ID_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TSID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TSID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tsid_pkg.sv =====
`timescale 1ns / 1ps

package tsid_pkg;

  // Field widths
  localparam int TICK_BITS   = 48;
  localparam int NOW_W       = 48;
  localparam int ID_W        = 63;
  localparam int SEQ_W       = 22;
  localparam int ORDER_W     = 3;
  localparam int COUNT_W     = 17;
  localparam int WORKER_W    = 15;
  localparam int SHIFT_W     = 5;
  localparam int MSEQ_W      = 21;
  localparam int COST_W      = 16;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;

  localparam logic [ORDER_W-1:0] ORDER_TOP = ORDER_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Register reset values
  localparam logic [WORKER_W-1:0] WORKER_ID_RST = '0;
  localparam logic [SHIFT_W-1:0]  SEQ_BITS_RST  = SHIFT_W'(6);
  localparam logic [SHIFT_W-1:0]  TS_SHIFT_RST  = SHIFT_W'(12);
  localparam logic [MSEQ_W-1:0]   MIN_SEQ_RST   = MSEQ_W'(5);
  localparam logic [MSEQ_W-1:0]   MAX_SEQ_RST   = MSEQ_W'(63);
  localparam logic [COST_W-1:0]   TOP_COST_RST  = COST_W'(2000);
  localparam logic [NOW_W-1:0]    BASE_TIME_RST = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WORKER_ID,
    REG_SEQ_BITS,
    REG_TS_SHIFT,
    REG_MIN_SEQ,
    REG_MAX_SEQ,
    REG_TOP_OVER_COST,
    REG_BASE_TIME
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_NORMAL,
    ST_BORROW,
    ST_ROLLBACK,
    ST_RETRY
  } id_status_t;

  typedef struct packed {
    logic [WORKER_W-1:0] worker_id;
    logic [SHIFT_W-1:0]  seq_bits;
    logic [SHIFT_W-1:0]  timestamp_shift;
    logic [MSEQ_W-1:0]   min_seq;
    logic [MSEQ_W-1:0]   max_seq;
    logic [COST_W-1:0]   top_over_cost;
    logic [NOW_W-1:0]    base_time;
  } cfg_t;

endpackage

// ===== src/tsid_req_if.sv =====
`timescale 1ns / 1ps

// Request channel: one item per request, carrying wall time
interface tsid_req_if import tsid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

// ===== src/tsid_rsp_if.sv =====
`timescale 1ns / 1ps

// Response channel: one item per request, id and status
interface tsid_rsp_if import tsid_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] id_value;
  logic [1:0]      id_status;

  modport source (output valid, output id_value, output id_status, input ready);
  modport sink   (input valid, input id_value, input id_status, output ready);
endinterface

// ===== src/tsid_compose.sv =====
`timescale 1ns / 1ps

// Packs tick, worker id and sequence into the 63-bit id.
// Fields are OR-ed, so overlapping layouts give the union of bits.
module tsid_compose import tsid_pkg::*; (
  input  cfg_t                 cfg,
  input  logic [TICK_BITS-1:0] tick,
  input  logic [SEQ_W-1:0]     seq,
  output logic [ID_W-1:0]      id
);

  logic [ID_W-1:0] tick_part;
  logic [ID_W-1:0] worker_part;

  // shifting within ID_W drops everything above bit 62
  assign tick_part   = ID_W'(tick) << cfg.timestamp_shift;
  assign worker_part = ID_W'(cfg.worker_id) << cfg.seq_bits;
  assign id          = tick_part | worker_part | ID_W'(seq);

endmodule

// ===== src/timestamp_id_generator.sv =====
`timescale 1ns / 1ps

// Snowflake-style id generator. Each request item carries the wall time in ms
// and returns one response item: id = tick << timestamp_shift | worker_id <<
// seq_bits | sequence, masked to 63 bits, with a status (normal, borrowed
// tick, rollback id, or retry with a zero id). One request is taken every
// cycle unless the sink stalls and the pipeline fills; a response passes the
// stage one, stage two and output registers. Stage one registers the tick
// (time minus base_time), stage two updates the sequence/borrow/rollback
// state in a single pass and picks tick and sequence, stage three composes
// the id. Stage two's state update is the only loop. The user must write
// registers on cfg_wr_en only while no request is in flight; not enforced.
module timestamp_id_generator import tsid_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  tsid_req_if.sink               req,
  tsid_rsp_if.source             rsp
);

  cfg_t cfg;

  // generator state
  logic [TICK_BITS-1:0] last_tick, last_tick_next;
  logic [SEQ_W-1:0]     seq_now, seq_now_next;
  logic                 borrowing, borrowing_next;
  logic [COUNT_W-1:0]   borrow_count, borrow_count_next;
  logic [TICK_BITS-1:0] rollback_tick, rollback_tick_next;
  logic [ORDER_W-1:0]   rollback_order, rollback_order_next;

  // pipeline registers
  logic                 a_valid;
  logic [TICK_BITS-1:0] a_tick;
  logic                 b_valid;
  logic [TICK_BITS-1:0] b_tick;
  logic [SEQ_W-1:0]     b_seq;
  id_status_t           b_status;
  logic                 o_valid;
  logic [ID_W-1:0]      o_id;
  id_status_t           o_status;

  // stage two selections
  logic [TICK_BITS-1:0] sel_tick;
  logic [SEQ_W-1:0]     sel_seq;
  id_status_t           sel_status;

  logic                 out_free, b_free, a_free, a_move, b_move;
  logic [TICK_BITS-1:0] in_tick;
  logic [ID_W-1:0]      comp_id;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.worker_id       <= WORKER_ID_RST;
      cfg.seq_bits        <= SEQ_BITS_RST;
      cfg.timestamp_shift <= TS_SHIFT_RST;
      cfg.min_seq         <= MIN_SEQ_RST;
      cfg.max_seq         <= MAX_SEQ_RST;
      cfg.top_over_cost   <= TOP_COST_RST;
      cfg.base_time       <= BASE_TIME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WORKER_ID:     cfg.worker_id       <= cfg_data[WORKER_W-1:0];
        REG_SEQ_BITS:      cfg.seq_bits        <= cfg_data[SHIFT_W-1:0];
        REG_TS_SHIFT:      cfg.timestamp_shift <= cfg_data[SHIFT_W-1:0];
        REG_MIN_SEQ:       cfg.min_seq         <= cfg_data[MSEQ_W-1:0];
        REG_MAX_SEQ:       cfg.max_seq         <= cfg_data[MSEQ_W-1:0];
        REG_TOP_OVER_COST: cfg.top_over_cost   <= cfg_data[COST_W-1:0];
        REG_BASE_TIME:     cfg.base_time       <= cfg_data[NOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: each stage moves when the one after it is free
  assign out_free  = !o_valid || rsp.ready;
  assign b_move    = b_valid && out_free;
  assign b_free    = !b_valid || out_free;
  assign a_move    = a_valid && b_free;
  assign a_free    = !a_valid || b_free;
  assign req.ready = a_free;

  // Tick from wall time; time before the epoch is tick zero
  assign in_tick = (req.now_ms >= cfg.base_time) ?
                   TICK_BITS'(req.now_ms - cfg.base_time) : '0;

  // Stage one: registered tick
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && req.valid) begin
      a_tick <= in_tick;
    end
  end

  // Stage two: state update and choice of tick and sequence
  always_comb begin
    logic [TICK_BITS-1:0] tick_step;
    logic [ORDER_W-1:0]   order_inc;
    logic [TICK_BITS-1:0] rb_base;
    logic [ORDER_W-1:0]   rb_order;

    last_tick_next      = last_tick;
    seq_now_next        = seq_now;
    borrowing_next      = borrowing;
    borrow_count_next   = borrow_count;
    rollback_tick_next  = rollback_tick;
    rollback_order_next = rollback_order;
    sel_tick            = last_tick;
    sel_seq             = seq_now;
    sel_status          = ST_NORMAL;
    tick_step           = last_tick + TICK_BITS'(1);
    order_inc           = rollback_order + ORDER_W'(1);
    rb_base             = rollback_tick;
    rb_order            = rollback_order;

    if (borrowing) begin
      if (a_tick > last_tick) begin
        // real time caught up: fresh tick, borrowing ends
        last_tick_next    = a_tick;
        sel_tick          = a_tick;
        sel_seq           = SEQ_W'(cfg.min_seq);
        seq_now_next      = SEQ_W'(cfg.min_seq) + SEQ_W'(1);
        borrowing_next    = 1'b0;
        borrow_count_next = '0;
        sel_status        = ST_NORMAL;
      end else if (borrow_count > COUNT_W'(cfg.top_over_cost)) begin
        // too far ahead: no id, state unchanged
        sel_status = ST_RETRY;
      end else begin
        if (seq_now > SEQ_W'(cfg.max_seq)) begin
          last_tick_next = tick_step;
          sel_tick       = tick_step;
          sel_seq        = SEQ_W'(cfg.min_seq);
          if (borrow_count < COUNT_MAX) begin
            borrow_count_next = borrow_count + COUNT_W'(1);
          end
        end
        seq_now_next = sel_seq + SEQ_W'(1);
        sel_status   = ST_BORROW;
      end
    end else if (a_tick < last_tick) begin
      // clock went back: reserved order as sequence, rollback tick counts down
      if (rollback_tick == '0) begin
        rb_base  = last_tick - TICK_BITS'(1);
        rb_order = (order_inc > ORDER_TOP) ? ORDER_W'(1) : order_inc;
      end
      rollback_order_next = rb_order;
      rollback_tick_next  = rb_base - TICK_BITS'(1);
      sel_tick            = rb_base;
      sel_seq             = SEQ_W'(rb_order);
      sel_status          = ST_ROLLBACK;
    end else begin
      rollback_tick_next = '0;
      if (a_tick > last_tick) begin
        last_tick_next = a_tick;
        sel_tick       = a_tick;
        sel_seq        = SEQ_W'(cfg.min_seq);
        sel_status     = ST_NORMAL;
      end else if (seq_now > SEQ_W'(cfg.max_seq)) begin
        // sequence used up: borrow the next tick
        last_tick_next    = tick_step;
        sel_tick          = tick_step;
        sel_seq           = SEQ_W'(cfg.min_seq);
        borrowing_next    = 1'b1;
        borrow_count_next = COUNT_W'(1);
        sel_status        = ST_BORROW;
      end else begin
        sel_status = ST_NORMAL;
      end
      seq_now_next = sel_seq + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick      <= '0;
      seq_now        <= SEQ_W'(MIN_SEQ_RST);
      borrowing      <= 1'b0;
      borrow_count   <= '0;
      rollback_tick  <= '0;
      rollback_order <= '0;
    end else if (a_move) begin
      last_tick      <= last_tick_next;
      seq_now        <= seq_now_next;
      borrowing      <= borrowing_next;
      borrow_count   <= borrow_count_next;
      rollback_tick  <= rollback_tick_next;
      rollback_order <= rollback_order_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_tick   <= sel_tick;
      b_seq    <= sel_seq;
      b_status <= sel_status;
    end
  end

  // Stage three: compose the id into the output register
  tsid_compose u_compose (
    .cfg  (cfg),
    .tick (b_tick),
    .seq  (b_seq),
    .id   (comp_id)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      o_id     <= (b_status == ST_RETRY) ? '0 : comp_id;
      o_status <= b_status;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.id_value  = o_id;
  assign rsp.id_status = o_status;

endmodule

// ===== src/tsid_checker.sv =====
`timescale 1ns / 1ps
`include "timestamp_id_generator_defines.svh"

// Port-level checks on the id generator
module tsid_checker import tsid_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input logic [ID_W-1:0] rsp_id_value,
  input logic [1:0]      rsp_id_status
);

  // a retry never carries an id
  `TSID_ASSERT_IMP(a_retry_zero, rsp_valid && (rsp_id_status == ST_RETRY), rsp_id_value == '0, "retry item carries a nonzero id")

  // a stalled response holds
  `TSID_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_id_value) && $stable(rsp_id_status), "stalled response changed")

  // pipeline is empty right after reset
  `TSID_ASSERT_IMP(a_empty_after_rst, $past(rst), !rsp_valid, "response present right after reset")

  // a draining sink never blocks requests
  `TSID_ASSERT_IMP(a_ready_passes, rsp_ready, req_ready, "request blocked while response sink is ready")

endmodule

bind timestamp_id_generator tsid_checker u_tsid_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_id_value  (rsp.id_value),
  .rsp_id_status (rsp.id_status)
);
